// ===== hw/rtl/pfcm_pkg.sv =====
// pfcm_pkg: types, codes and sizes shared by the page frame clock manager
// no dependencies
package pfcm_pkg;
  localparam int NUM_FRAMES = 16;
  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int MAX_WRITEBACKS = 16;
  localparam int QDEPTH = 2;

  localparam logic [2:0] OP_FETCH = 3'd0;
  localparam logic [2:0] OP_UNPIN = 3'd1;
  localparam logic [2:0] OP_DIRTY = 3'd2;
  localparam logic [2:0] OP_INVAL = 3'd3;
  localparam logic [2:0] OP_INVALL = 3'd4;
  localparam logic [2:0] OP_FLUSH = 3'd5;

  localparam logic [2:0] KIND_HIT = 3'd0;
  localparam logic [2:0] KIND_MISS = 3'd1;
  localparam logic [2:0] KIND_WB = 3'd2;
  localparam logic [2:0] KIND_FAIL = 3'd3;
  localparam logic [2:0] KIND_ACK = 3'd4;

  localparam logic [1:0] USAGE_MAX = 2'd3;
  localparam logic [7:0] PIN_MAX = 8'd255;

  typedef struct packed {
    logic [2:0] opcode;
    logic [31:0] page_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] frame;
    logic [31:0] page;
    logic last;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [2:0] opcode;
    logic [31:0] page_id;
  } cmd_t;

  function automatic logic [3:0] frame_field(input logic [FW-1:0] f);
    logic [FW+3:0] w;
    w = {4'd0, f};
    return w[3:0];
  endfunction
endpackage

// ===== hw/rtl/pfcm_front.sv =====
// pfcm_front: accepts input items and holds them in a short command queue
// depends on pfcm_pkg
module pfcm_front import pfcm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);
  cmd_t q_r [QDEPTH];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  assign in_full = (cnt_r == 2'(QDEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_push && !in_full) begin
        q_r[wr_r] <= '{opcode: in_item.opcode, page_id: in_item.page_id};
        wr_r <= ~wr_r;
      end
      if (cmd_take && cmd_valid) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(in_push && !in_full) - 2'(cmd_take && cmd_valid);
    end
  end
endmodule

// ===== hw/rtl/pfcm_back.sv =====
// pfcm_back: frame table and sequencer for lookup, sweep and flush
// depends on pfcm_pkg
module pfcm_back import pfcm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] boost,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_take
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [31:0] tag_r [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r, dirty_r;
  logic [7:0] pins_r [NUM_FRAMES];
  logic [1:0] usage_r [NUM_FRAMES];
  logic [FW-1:0] hand_r, idx_r;
  logic [2:0] state_r;
  cmd_t cur_r;
  logic changed_r;
  logic [FW:0] ncnt_r;
  logic [2:0] pass_r;
  logic [4:0] wbcnt_r;
  logic ov_r;
  out_item_t ob_r;

  // one-step combinational lookups
  logic hit;
  logic [FW-1:0] hit_idx;
  logic freef;
  logic [FW-1:0] free_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    freef = 1'b0;
    free_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == cur_r.page_id) begin
        hit = 1'b1;
        hit_idx = FW'(i);
      end
      if (!valid_r[i] && pins_r[i] == 8'd0) begin
        freef = 1'b1;
        free_idx = FW'(i);
      end
    end
  end

  // page-addressed commands echo their page, the rest report zero
  logic [31:0] ack_page;
  assign ack_page = (cur_r.opcode inside {OP_FETCH, OP_UNPIN, OP_DIRTY, OP_INVAL}) ?
                    cur_r.page_id : 32'd0;

  logic ob_free;
  assign ob_free = !ov_r || res_take;
  assign res_valid = ov_r;
  assign res = ob_r;
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  logic [FW-1:0] hand_inc;
  assign hand_inc = (hand_r == FW'(NUM_FRAMES - 1)) ? '0 : hand_r + 1'b1;
  logic [FW-1:0] idx_inc;
  assign idx_inc = idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      hand_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pins_r[i] <= 8'd0;
        usage_r[i] <= 2'd0;
      end
    end else begin
      if (res_take) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ob_free) begin
            ov_r <= 1'b1;
            ob_r <= '{kind: KIND_ACK, frame: 4'd0, page: ack_page, last: 1'b1};
            state_r <= S_IDLE;
            case (cur_r.opcode)
              OP_FETCH: begin
                if (hit) begin
                  if (pins_r[hit_idx] != PIN_MAX) pins_r[hit_idx] <= pins_r[hit_idx] + 8'd1;
                  usage_r[hit_idx] <= boost;
                  ob_r <= '{kind: KIND_HIT, frame: frame_field(hit_idx),
                            page: cur_r.page_id, last: 1'b1};
                end else if (freef) begin
                  tag_r[free_idx] <= cur_r.page_id;
                  valid_r[free_idx] <= 1'b1;
                  dirty_r[free_idx] <= 1'b0;
                  pins_r[free_idx] <= 8'd1;
                  usage_r[free_idx] <= boost;
                  ob_r <= '{kind: KIND_MISS, frame: frame_field(free_idx),
                            page: cur_r.page_id, last: 1'b1};
                end else begin
                  ov_r <= 1'b0;
                  changed_r <= 1'b0;
                  ncnt_r <= '0;
                  pass_r <= '0;
                  state_r <= S_SWEEP;
                end
              end
              OP_UNPIN: if (hit && pins_r[hit_idx] != 8'd0)
                pins_r[hit_idx] <= pins_r[hit_idx] - 8'd1;
              OP_DIRTY: if (hit) dirty_r[hit_idx] <= 1'b1;
              OP_INVAL: if (hit) begin
                valid_r[hit_idx] <= 1'b0;
                dirty_r[hit_idx] <= 1'b0;
                pins_r[hit_idx] <= 8'd0;
                usage_r[hit_idx] <= 2'd0;
              end
              OP_INVALL: begin
                valid_r <= '0;
                dirty_r <= '0;
                for (int i = 0; i < NUM_FRAMES; i++) begin
                  pins_r[i] <= 8'd0;
                  usage_r[i] <= 2'd0;
                end
              end
              OP_FLUSH: begin
                ov_r <= 1'b0;
                idx_r <= '0;
                wbcnt_r <= '0;
                state_r <= S_FLUSH;
              end
              default: ;
            endcase
          end
        end
        // one frame per cycle from the hand
        S_SWEEP: begin
          if (ob_free) begin
            hand_r <= hand_inc;
            if (pins_r[hand_r] != 8'd0) begin
            end else if (usage_r[hand_r] != 2'd0) begin
              usage_r[hand_r] <= usage_r[hand_r] - 2'd1;
              changed_r <= 1'b1;
            end else begin
              idx_r <= hand_r;
              if (valid_r[hand_r] && dirty_r[hand_r]) begin
                ov_r <= 1'b1;
                ob_r <= '{kind: KIND_WB, frame: frame_field(hand_r),
                          page: tag_r[hand_r], last: 1'b0};
              end
              state_r <= S_LOAD;
            end
            if (!(pins_r[hand_r] == 8'd0 && usage_r[hand_r] == 2'd0)) begin
              if (ncnt_r == (FW+1)'(NUM_FRAMES - 1)) begin
                ncnt_r <= '0;
                pass_r <= pass_r + 3'd1;
                changed_r <= 1'b0;
                if (!(changed_r || pins_r[hand_r] == 8'd0) ||
                    pass_r == 3'(USAGE_MAX + 1)) begin
                  ov_r <= 1'b1;
                  ob_r <= '{kind: KIND_FAIL, frame: 4'd0, page: cur_r.page_id,
                            last: 1'b1};
                  state_r <= S_IDLE;
                end
              end else begin
                ncnt_r <= ncnt_r + 1'b1;
              end
            end
          end
        end
        S_LOAD: begin
          if (ob_free) begin
            tag_r[idx_r] <= cur_r.page_id;
            valid_r[idx_r] <= 1'b1;
            dirty_r[idx_r] <= 1'b0;
            pins_r[idx_r] <= 8'd1;
            usage_r[idx_r] <= boost;
            ov_r <= 1'b1;
            ob_r <= '{kind: KIND_MISS, frame: frame_field(idx_r),
                      page: cur_r.page_id, last: 1'b1};
            state_r <= S_IDLE;
          end
        end
        // one frame per cycle in index order, while the result register is free
        S_FLUSH: begin
          if (ob_free) begin
            if (valid_r[idx_r] && dirty_r[idx_r] && wbcnt_r != 5'(MAX_WRITEBACKS)) begin
              dirty_r[idx_r] <= 1'b0;
              wbcnt_r <= wbcnt_r + 5'd1;
              ov_r <= 1'b1;
              ob_r <= '{kind: KIND_WB, frame: frame_field(idx_r),
                        page: tag_r[idx_r], last: 1'b0};
            end
            if (idx_r == FW'(NUM_FRAMES - 1)) state_r <= S_EXEC;
            else idx_r <= idx_inc;
            if (idx_r == FW'(NUM_FRAMES - 1)) cur_r.opcode <= OP_INVALL + 3'd2;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/page_frame_clock_manager.sv =====
// page_frame_clock_manager: top level, page to frame table with clock sweep
// path: a pushed item is queued in the front, then taken and executed by the back sequencer
// the back sequencer takes a new command only once it is back in idle; a miss with no free
// frame sweeps the clock hand over the frames before the load, and a flush visits every frame
// the back sequencer visits one frame per cycle while its result register is free
// reset: synchronous active low; table empty, hand at zero, usage_boost 3
module page_frame_clock_manager import pfcm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_usage_boost
);
  logic [1:0] boost_r;
  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;

  // config register; to be written only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) boost_r <= USAGE_MAX;
    else if (cfg_valid) boost_r <= cfg_usage_boost;
  end

  // front: command queue
  pfcm_front u_front (
    .clk, .rst_n, .in_push, .in_item, .in_full,
    .cmd_valid, .cmd, .cmd_take
  );

  // back: table and sequencer with result register
  pfcm_back u_back (
    .clk, .rst_n, .boost(boost_r), .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res(out_item), .res_take(out_pop)
  );

  assign out_empty = !res_valid;
endmodule

// ===== hw/rtl/pfcm_checker.sv =====
// pfcm_checker: port-level assertions for the page frame clock manager
// depends on pfcm_pkg; bound to page_frame_clock_manager
module pfcm_checker import pfcm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while waiting");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.kind <= KIND_ACK)
    else $error("bad kind");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_item.kind == KIND_HIT || out_item.kind == KIND_MISS ||
                   out_item.kind == KIND_ACK || out_item.kind == KIND_FAIL)
    |-> out_item.last)
    else $error("final result without last");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind == KIND_WB |-> !out_item.last)
    else $error("write back flagged last");
endmodule

bind page_frame_clock_manager pfcm_checker u_pfcm_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_item
);
